>>> src/gcsrf_pkg.sv
// Shared constants, types and address helper for the grid cell store with rectangle fill.
`default_nettype none
package gcsrf_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int VALUE_BITS = 16;

   localparam int MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
   localparam int IDX_BITS  = $clog2(MAX_DIM);
   localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int SPAN_BITS = ($clog2(MAX_DIM + 1) > 9) ? $clog2(MAX_DIM + 1) : 9;
   localparam int CALC_BITS = SPAN_BITS + 2;

   localparam int ACTION_BITS    = 2;
   localparam int COORD_BITS     = 8;
   localparam int DATA_BITS      = 16;
   localparam int SIZE_BITS      = 7;
   localparam int ORG_BITS       = 6;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 7;
   localparam int REQ_DATA_BITS  = 4 * COORD_BITS + DATA_BITS;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_FILL  = 2'd2
   } action_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_ORIGIN_COL  = 2'd2,
      CSR_ORIGIN_ROW  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_RDWAIT,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] first;
      logic [IDX_BITS-1:0] last;
      logic                empty;
   } span_type;

   function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [ROW_BITS-1:0] row,
                                                      input logic [COL_BITS-1:0] col);
      return ADDR_BITS'(row) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(col);
   endfunction

endpackage
`default_nettype wire

>>> src/gcsrf_clip.sv
// Span normalizer: map a signed corner and extent to array indexes and clip to the grid.
`default_nettype none
module gcsrf_clip (
   input  logic signed [gcsrf_pkg::COORD_BITS-1:0] corner,
   input  logic signed [gcsrf_pkg::COORD_BITS-1:0] extent,
   input  logic        [gcsrf_pkg::ORG_BITS-1:0]   origin,
   input  logic        [gcsrf_pkg::SPAN_BITS-1:0]  limit,
   output gcsrf_pkg::span_type                     span
);
   import gcsrf_pkg::*;

   localparam logic signed [CALC_BITS-1:0] CALC_ONE  = CALC_BITS'(1);
   localparam logic signed [CALC_BITS-1:0] CALC_ZERO = CALC_BITS'(0);

   logic signed [CALC_BITS-1:0] corner_ext;
   logic signed [CALC_BITS-1:0] extent_ext;
   logic signed [CALC_BITS-1:0] lim;
   logic signed [CALC_BITS-1:0] base;
   logic signed [CALC_BITS-1:0] size;
   logic signed [CALC_BITS-1:0] lo;
   logic signed [CALC_BITS-1:0] hi;
   logic signed [CALC_BITS-1:0] lo_clip;
   logic signed [CALC_BITS-1:0] hi_clip;

   always_comb begin
      corner_ext = CALC_BITS'(corner);
      extent_ext = CALC_BITS'(extent);
      lim        = CALC_BITS'(limit);
      // flip a negative extent so the span grows rightward from its low end
      if (extent_ext < CALC_ZERO) begin
         base = corner_ext + extent_ext + CALC_ONE;
         size = CALC_ZERO - extent_ext;
      end else begin
         base = corner_ext;
         size = extent_ext;
      end
      lo = base + CALC_BITS'(origin);
      hi = lo + size;
      priority if (lo < CALC_ZERO) begin
         lo_clip = CALC_ZERO;
      end else if (lo > lim) begin
         lo_clip = lim;
      end else begin
         lo_clip = lo;
      end
      priority if (hi > lim) begin
         hi_clip = lim;
      end else if (hi < CALC_ZERO) begin
         hi_clip = CALC_ZERO;
      end else begin
         hi_clip = hi;
      end
      span.empty = (hi_clip <= lo_clip);
      span.first = IDX_BITS'(lo_clip);
      span.last  = IDX_BITS'(hi_clip - CALC_ONE);
   end

endmodule
`default_nettype wire

>>> src/grid_cell_store_rect_fill_unit.sv
// Grid cell store: signed-coordinate cell read, cell write and clipped rectangle fill.
//
// Usage: one request word on req_* holds an action (req_tuser) and its operands
// (req_tdata). Every request yields exactly one response word on rsp_*: the cell
// value for a successful read (zero otherwise) in rsp_tdata and an error flag
// (range error or unknown action) in rsp_tuser. Grid size and origin are written
// on the csr_* port, always ready; write it only while no request is in flight.
// Timing: one request at a time, set by the state machine. A read passes through
// decode, read-wait and done, a write or any error through decode and done, and a
// fill through decode, fill and done, writing one cell per cycle. req_tready rises
// on the same edge that loads the response, so a new request is not accepted
// until the last one has loaded its response.
// Reset: registers take their reset values, then a clearing pass writes zero to
// all MAX_WIDTH * MAX_HEIGHT cells, one per cycle, while req_tready stays low.
// Stall: the response is held in an output register; a finished request waits
// for it to drain while rsp_tready is low and no new request is accepted.
`default_nettype none
module grid_cell_store_rect_fill_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: coord_x[7:0], coord_y[15:8], extent_x[23:16], extent_y[31:24],
   //            cell_value[47:32]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [gcsrf_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // req_tuser: action[1:0]
   input  logic [gcsrf_pkg::ACTION_BITS-1:0]     req_tuser,
   // rsp_tdata: read_value[15:0]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [gcsrf_pkg::DATA_BITS-1:0]       rsp_tdata,
   // rsp_tuser: status[0]
   output logic                                  rsp_tuser,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gcsrf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gcsrf_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import gcsrf_pkg::*;

   localparam logic signed [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

   state_type                     state_ff, state_in;
   logic [ADDR_BITS-1:0]          clear_addr_ff, clear_addr_in;
   logic [SIZE_BITS-1:0]          grid_width_ff, grid_height_ff;
   logic [ORG_BITS-1:0]           origin_col_ff, origin_row_ff;

   action_type                    action_ff;
   logic signed [COORD_BITS-1:0]  coord_x_ff, coord_y_ff, extent_x_ff, extent_y_ff;
   logic signed [DATA_BITS-1:0]   cell_value_ff;

   logic [COL_BITS-1:0]           col_ff, col_in, col_first_ff, col_first_in;
   logic [COL_BITS-1:0]           col_last_ff, col_last_in;
   logic [ROW_BITS-1:0]           row_ff, row_in, row_last_ff, row_last_in;

   logic [DATA_BITS-1:0]          res_value_ff, res_value_in;
   logic                          res_status_ff, res_status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]          rsp_data_ff;
   logic                          rsp_status_ff;
   logic                          rsp_load;

   logic [SPAN_BITS-1:0]          width_lim, height_lim;
   logic signed [COORD_BITS-1:0]  span_ext_x, span_ext_y;
   span_type                      col_span, row_span;
   logic                          span_ok;
   logic [ADDR_BITS-1:0]          point_addr;

   logic [VALUE_BITS-1:0]         cell_grid_mem [DEPTH];
   logic                          mem_we;
   logic [ADDR_BITS-1:0]          mem_waddr;
   logic [VALUE_BITS-1:0]         mem_wdata;
   logic [VALUE_BITS-1:0]         mem_rd_ff;

   logic                          req_accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // effective grid size, capped at the built size
   assign width_lim  = (SPAN_BITS'(grid_width_ff) > SPAN_BITS'(MAX_WIDTH)) ?
                       SPAN_BITS'(MAX_WIDTH) : SPAN_BITS'(grid_width_ff);
   assign height_lim = (SPAN_BITS'(grid_height_ff) > SPAN_BITS'(MAX_HEIGHT)) ?
                       SPAN_BITS'(MAX_HEIGHT) : SPAN_BITS'(grid_height_ff);

   // a point access is a one-cell span
   assign span_ext_x = (action_ff == ACT_FILL) ? extent_x_ff : COORD_ONE;
   assign span_ext_y = (action_ff == ACT_FILL) ? extent_y_ff : COORD_ONE;

   gcsrf_clip u_clip_col (
      .corner (coord_x_ff),
      .extent (span_ext_x),
      .origin (origin_col_ff),
      .limit  (width_lim),
      .span   (col_span)
   );

   gcsrf_clip u_clip_row (
      .corner (coord_y_ff),
      .extent (span_ext_y),
      .origin (origin_row_ff),
      .limit  (height_lim),
      .span   (row_span)
   );

   assign span_ok    = !col_span.empty && !row_span.empty;
   assign point_addr = cell_addr(ROW_BITS'(row_span.first), COL_BITS'(col_span.first));

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= SIZE_BITS'(63);
         grid_height_ff <= SIZE_BITS'(63);
         origin_col_ff  <= ORG_BITS'(31);
         origin_row_ff  <= ORG_BITS'(31);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_data[SIZE_BITS-1:0];
            CSR_GRID_HEIGHT: grid_height_ff <= csr_data[SIZE_BITS-1:0];
            CSR_ORIGIN_COL:  origin_col_ff  <= csr_data[ORG_BITS-1:0];
            CSR_ORIGIN_ROW:  origin_row_ff  <= csr_data[ORG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         action_ff     <= action_type'(req_tuser);
         coord_x_ff    <= $signed(req_tdata[7:0]);
         coord_y_ff    <= $signed(req_tdata[15:8]);
         extent_x_ff   <= $signed(req_tdata[23:16]);
         extent_y_ff   <= $signed(req_tdata[31:24]);
         cell_value_ff <= $signed(req_tdata[47:32]);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_grid_mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= cell_grid_mem[point_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff        <= col_in;
      col_first_ff  <= col_first_in;
      col_last_ff   <= col_last_in;
      row_ff        <= row_in;
      row_last_ff   <= row_last_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_data_ff   <= res_value_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      col_in        = col_ff;
      col_first_in  = col_first_ff;
      col_last_in   = col_last_ff;
      row_in        = row_ff;
      row_last_in   = row_last_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = cell_addr(row_ff, col_ff);
      mem_wdata     = VALUE_BITS'(cell_value_ff);
      rsp_load      = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we        = 1'b1;
            mem_waddr     = clear_addr_ff;
            mem_wdata     = '0;
            clear_addr_in = clear_addr_ff + ADDR_BITS'(1);
            if (clear_addr_ff == ADDR_BITS'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_value_in  = '0;
            res_status_in = !span_ok;
            state_in      = ST_DONE;
            unique case (action_ff)
               ACT_READ: begin
                  if (span_ok) begin
                     state_in = ST_RDWAIT;
                  end
               end
               ACT_WRITE: begin
                  mem_we    = span_ok;
                  mem_waddr = point_addr;
               end
               ACT_FILL: begin
                  col_in       = COL_BITS'(col_span.first);
                  col_first_in = COL_BITS'(col_span.first);
                  col_last_in  = COL_BITS'(col_span.last);
                  row_in       = ROW_BITS'(row_span.first);
                  row_last_in  = ROW_BITS'(row_span.last);
                  if (span_ok) begin
                     res_status_in = 1'b0;
                     state_in      = ST_FILL;
                  end
               end
               default: begin
                  res_status_in = 1'b1;
               end
            endcase
         end
         ST_RDWAIT: begin
            res_value_in = DATA_BITS'($signed(mem_rd_ff));
            state_in     = ST_DONE;
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (col_ff == col_last_ff) begin
               col_in = col_first_ff;
               if (row_ff == row_last_ff) begin
                  state_in = ST_DONE;
               end else begin
                  row_in = row_ff + ROW_BITS'(1);
               end
            end else begin
               col_in = col_ff + COL_BITS'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule
`default_nettype wire

>>> src/gcsrf_checker.sv
// Port-level checks for the grid cell store, bound to the top level.
`default_nettype none
module gcsrf_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [gcsrf_pkg::DATA_BITS-1:0]       rsp_tdata,
   input logic                                  rsp_tuser
);
   import gcsrf_pkg::*;

   // clearing pass keeps requests out right after reset
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request channel ready during clearing pass");

   // one request in flight at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while one is in flight");

   // an error response carries a zero value
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("error response with nonzero value");

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("response dropped while stalled");

endmodule

bind grid_cell_store_rect_fill_unit gcsrf_checker u_gcsrf_checker (.*);
`default_nettype wire
